@@ src/wfsr_pkg.sv @@
package wfsr_pkg;

  // stream and configuration port widths
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned AddrW    = 5;

  // speed to step rate scale, Q16
  localparam logic signed [18:0] StepsPerMmQ16 = 19'sd231584;

  // gating thresholds
  localparam logic [11:0] SideSpeedMin  = 12'd200;
  localparam logic [11:0] FrontSpeedMin = 12'd100;
  localparam logic [11:0] FrontSpeedMax = 12'd300;
  localparam logic [11:0] FrontNearMin  = 12'd700;

  // sensor change limits for wall acceptance
  localparam logic signed [12:0] BothChangeMax = 13'sd10;
  localparam logic signed [12:0] OneChangeMax  = 13'sd7;

  // side clamp, Q16.16 and integer
  localparam logic signed [47:0] SideLimQ16 = 48'sd6553600;
  localparam logic signed [7:0]  SideMax    = 8'sd100;
  localparam logic signed [7:0]  SideMin    = -8'sd100;

  // front saturation
  localparam logic signed [20:0] FrontMax = 21'sd32767;
  localparam logic signed [20:0] FrontMin = -21'sd32768;

  // register map
  typedef enum logic [2:0] {
    REG_SIDE_GAIN_P     = 3'd0,
    REG_SIDE_GAIN_D     = 3'd1,
    REG_FRONT_GAIN_P    = 3'd2,
    REG_LEFT_REFERENCE  = 3'd3,
    REG_RIGHT_REFERENCE = 3'd4,
    REG_LEFT_THRESHOLD  = 3'd5,
    REG_RIGHT_THRESHOLD = 3'd6,
    REG_FRONT_REFERENCE = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] side_gain_p;
    logic [15:0] side_gain_d;
    logic [15:0] front_gain_p;
    logic [11:0] left_reference;
    logic [11:0] right_reference;
    logic [11:0] left_threshold;
    logic [11:0] right_threshold;
    logic [11:0] front_reference;
  } cfg_t;

  // shared multiplier operand selection
  typedef enum logic [1:0] {
    MUL_BASE  = 2'd0,
    MUL_PROP  = 2'd1,
    MUL_DERIV = 2'd2,
    MUL_FRONT = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic     cap_in;
    mul_sel_e mul_sel;
    logic     cap_base;
    logic     cap_p;
    logic     cap_d;
    logic     cap_side;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ src/wfsr_regs.sv @@
module wfsr_regs import wfsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [31:0]      pwdata_i,
  output logic [31:0]      prdata_o,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = reg_idx_e'(paddr_i[AddrW-1:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.side_gain_p     <= 16'd256;
      cfg_q.side_gain_d     <= 16'd0;
      cfg_q.front_gain_p    <= 16'd0;
      cfg_q.left_reference  <= 12'd0;
      cfg_q.right_reference <= 12'd0;
      cfg_q.left_threshold  <= 12'd4095;
      cfg_q.right_threshold <= 12'd4095;
      cfg_q.front_reference <= 12'd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SIDE_GAIN_P:     cfg_q.side_gain_p     <= pwdata_i[15:0];
        REG_SIDE_GAIN_D:     cfg_q.side_gain_d     <= pwdata_i[15:0];
        REG_FRONT_GAIN_P:    cfg_q.front_gain_p    <= pwdata_i[15:0];
        REG_LEFT_REFERENCE:  cfg_q.left_reference  <= pwdata_i[11:0];
        REG_RIGHT_REFERENCE: cfg_q.right_reference <= pwdata_i[11:0];
        REG_LEFT_THRESHOLD:  cfg_q.left_threshold  <= pwdata_i[11:0];
        REG_RIGHT_THRESHOLD: cfg_q.right_threshold <= pwdata_i[11:0];
        REG_FRONT_REFERENCE: cfg_q.front_reference <= pwdata_i[11:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_SIDE_GAIN_P:     prdata_o = {16'd0, cfg_q.side_gain_p};
      REG_SIDE_GAIN_D:     prdata_o = {16'd0, cfg_q.side_gain_d};
      REG_FRONT_GAIN_P:    prdata_o = {16'd0, cfg_q.front_gain_p};
      REG_LEFT_REFERENCE:  prdata_o = {20'd0, cfg_q.left_reference};
      REG_RIGHT_REFERENCE: prdata_o = {20'd0, cfg_q.right_reference};
      REG_LEFT_THRESHOLD:  prdata_o = {20'd0, cfg_q.left_threshold};
      REG_RIGHT_THRESHOLD: prdata_o = {20'd0, cfg_q.right_threshold};
      REG_FRONT_REFERENCE: prdata_o = {20'd0, cfg_q.front_reference};
      default:             prdata_o = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/wfsr_ctrl.sv @@
module wfsr_ctrl import wfsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_BASE  = 7'b0000010,
    ST_PROP  = 7'b0000100,
    ST_DERIV = 7'b0001000,
    ST_FRONT = 7'b0010000,
    ST_SIDE  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // sequencing of the shared multiplier and result capture
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_BASE;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd_o.mul_sel = MUL_BASE;
        state_d       = ST_PROP;
      end
      ST_PROP: begin
        cmd_o.mul_sel  = MUL_PROP;
        cmd_o.cap_base = 1'b1;
        state_d        = ST_DERIV;
      end
      ST_DERIV: begin
        cmd_o.mul_sel = MUL_DERIV;
        cmd_o.cap_p   = 1'b1;
        state_d       = ST_FRONT;
      end
      ST_FRONT: begin
        cmd_o.mul_sel = MUL_FRONT;
        cmd_o.cap_d   = 1'b1;
        state_d       = ST_SIDE;
      end
      ST_SIDE: begin
        cmd_o.cap_side = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/wfsr_dp.sv @@
module wfsr_dp import wfsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  cfg_t                cfg_i,
  input  logic [InDataW-1:0]  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  // captured input item
  logic [11:0]        speed_q, lnow_q, rnow_q, fnow_q;
  logic signed [12:0] lchg_q, rchg_q;
  logic               act_q, rot_q, rev_q;

  // intermediate results
  logic signed [49:0] mul_q;
  logic [13:0]        base_q;
  logic signed [29:0] p_q;
  logic signed [46:0] d_q;
  logic signed [29:0] prev_q;
  logic signed [7:0]  side_q;
  logic signed [15:0] front_q;

  // output register
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // wall detection and side error selection
  logic               side_gate, front_gate;
  logic               lwall, rwall, both_mode, left_mode, right_mode;
  logic signed [12:0] lerr, rerr, ferr;
  logic signed [13:0] err_sel;

  assign side_gate  = act_q & ~rot_q & (speed_q > SideSpeedMin);
  assign front_gate = ~act_q & (speed_q > FrontSpeedMin) & (speed_q < FrontSpeedMax)
                    & (fnow_q > FrontNearMin);
  assign lwall      = lnow_q > cfg_i.left_threshold;
  assign rwall      = rnow_q > cfg_i.right_threshold;
  assign both_mode  = lwall & rwall & (lchg_q < BothChangeMax) & (rchg_q < BothChangeMax);
  assign left_mode  = lwall & (lchg_q < OneChangeMax) & (rchg_q < OneChangeMax);
  assign right_mode = rwall & (lchg_q < OneChangeMax) & (rchg_q < OneChangeMax);
  assign lerr = $signed({1'b0, lnow_q}) - $signed({1'b0, cfg_i.left_reference});
  assign rerr = $signed({1'b0, rnow_q}) - $signed({1'b0, cfg_i.right_reference});
  assign ferr = $signed({1'b0, fnow_q}) - $signed({1'b0, cfg_i.front_reference});

  always_comb begin
    if (both_mode) begin
      err_sel = {lerr[12], lerr} - {rerr[12], rerr};
    end else if (left_mode) begin
      err_sel = {lerr[12], lerr};
    end else if (right_mode) begin
      err_sel = $signed({2'b00, cfg_i.right_reference}) - $signed({2'b00, rnow_q});
    end else begin
      err_sel = '0;
    end
  end

  // shared multiplier operands
  logic signed [30:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [49:0] mul_p;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_BASE: begin
        mul_a = $signed({19'd0, speed_q});
        mul_b = StepsPerMmQ16;
      end
      MUL_PROP: begin
        mul_a = {{17{err_sel[13]}}, err_sel};
        mul_b = $signed({3'd0, cfg_i.side_gain_p});
      end
      MUL_DERIV: begin
        mul_a = {mul_q[29], mul_q[29:0]} - {prev_q[29], prev_q};
        mul_b = $signed({3'd0, cfg_i.side_gain_d});
      end
      MUL_FRONT: begin
        mul_a = {{18{ferr[12]}}, ferr};
        mul_b = $signed({3'd0, cfg_i.front_gain_p});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // side value in Q16.16, clamped and truncated toward zero; zero while the side gate is closed
  logic signed [47:0] side_val;
  logic signed [7:0]  side_trunc, side_next;

  assign side_val = {{10{p_q[29]}}, p_q, 8'd0} + {d_q[46], d_q};

  always_comb begin
    side_trunc = side_val[23:16];
    if (side_val[47] && (side_val[15:0] != 16'd0)) begin
      side_trunc = side_val[23:16] + 8'sd1;
    end
    if (!side_gate) begin
      side_next = '0;
    end else if (side_val > SideLimQ16) begin
      side_next = SideMax;
    end else if (side_val < -SideLimQ16) begin
      side_next = SideMin;
    end else begin
      side_next = side_trunc;
    end
  end

  // front value: Q8.8 product truncated toward zero, then saturated; zero while the front gate is closed
  logic signed [20:0] front_trunc;
  logic signed [15:0] front_next;

  always_comb begin
    front_trunc = mul_q[28:8];
    if (mul_q[28] && (mul_q[7:0] != 8'd0)) begin
      front_trunc = mul_q[28:8] + 21'sd1;
    end
    if (!front_gate) begin
      front_next = '0;
    end else if (front_trunc > FrontMax) begin
      front_next = 16'sh7fff;
    end else if (front_trunc < FrontMin) begin
      front_next = 16'sh8000;
    end else begin
      front_next = front_trunc[15:0];
    end
  end

  // wheel sums; the ranges of base, side and front keep these inside 17 bits
  logic signed [17:0] b18, s18, f18, lsum, rsum;

  assign b18 = $signed({4'd0, base_q});
  assign s18 = {{10{side_q[7]}}, side_q};
  assign f18 = {{2{front_q[15]}}, front_q};

  always_comb begin
    if (rev_q) begin
      lsum = s18 - b18;
      rsum = -b18 - s18;
    end else begin
      lsum = b18 + s18 - f18;
      rsum = b18 - s18 - f18;
    end
  end

  // input capture and datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      speed_q <= in_data_i[11:0];
      lnow_q  <= in_data_i[23:12];
      lchg_q  <= in_data_i[36:24];
      rnow_q  <= in_data_i[48:37];
      rchg_q  <= in_data_i[61:49];
      fnow_q  <= in_data_i[73:62];
      act_q   <= in_data_i[74];
      rot_q   <= in_data_i[75];
      rev_q   <= in_data_i[76];
    end
    mul_q <= mul_p;
    if (cmd_i.cap_base) begin
      base_q <= mul_q[29:16];
    end
    if (cmd_i.cap_p) begin
      p_q <= mul_q[29:0];
    end
    if (cmd_i.cap_d) begin
      d_q <= both_mode ? mul_q[46:0] : '0;
    end
    if (cmd_i.cap_side) begin
      side_q  <= side_next;
      front_q <= front_next;
    end
    if (cmd_i.load_out) begin
      out_data_q <= {6'd0, front_q, side_q, rsum[16:0], lsum[16:0]};
    end
  end

  // stored proportional product (side error times side P gain), updated only while the side gate is open
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (cmd_i.cap_side && side_gate) begin
      prev_q <= p_q;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

@@ src/wall_follow_step_rate_controller_unit.sv @@
// Wall-following step-rate controller: one control tick per input transfer. An item goes
// from acceptance to a loaded result through four passes of the one shared 31x19
// multiplier (base rate, proportional, derivative, front), a clamp step and an output
// load step; one item is in work at a time, so a new item is accepted only after the
// previous one is loaded. The next item is accepted while the previous result still
// waits in the output register, and it then holds in its load step until that register
// frees. Registers sit on the APB port at byte address 4*i and may be written only while
// no item is in flight.
module wall_follow_step_rate_controller_unit import wfsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // speed[11:0], left_now[23:12], left_change[36:24], right_now[48:37],
  // right_change[61:49], front_now[73:62], act[74], rotating[75], reverse[76]
  input  logic [InDataW-1:0]  s_tdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  // left_rate_delta[16:0], right_rate_delta[33:17], side_correction[41:34],
  // front_correction[57:42]
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  // configuration registers
  wfsr_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // sequencer
  wfsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and output register
  wfsr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg),
    .in_data_i   (s_tdata),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_o  (m_tdata)
  );

endmodule

@@ src/wfsr_checker.sv @@
module wfsr_checker import wfsr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  // a held result keeps its value until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // side correction stays within its clamp and padding stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> ($signed(m_tdata[41:34]) >= -8'sd100) && ($signed(m_tdata[41:34]) <= 8'sd100)
                 && (m_tdata[63:58] == 6'd0))
    else $error("side correction out of range");

  // side and front corrections are gated by opposite values of act
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tdata[41:34] != 8'd0) |-> m_tdata[57:42] == 16'd0)
    else $error("side and front correction both active");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

endmodule

bind wall_follow_step_rate_controller_unit wfsr_checker u_wfsr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
